// ===== design/wrg_pkg.sv =====
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types and constants for the water ripple height grid.
// ----------------------------------------------------------------------------
package wrg_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 256;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = MAX_COLS * MAX_ROWS;

    // divide by 1000 as multiply by ceil(2^36 / 1000), exact for 26-bit products
    localparam logic [26:0] K_RECIP = 27'd68719477;
    localparam int          K_SHIFT = 36;

    // function codes
    localparam logic [1:0] FN_RIPPLE = 2'd0;
    localparam logic [1:0] FN_UPDATE = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_DAMP = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RIP_RD,
        ST_RIP_WR,
        ST_RD_WAIT,
        ST_K_MUL,
        ST_K_DIV,
        ST_UPD_RD,
        ST_UPD_WAIT,
        ST_UPD_CALC,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic             clr_wr;    // write zero at sweep address
        logic             rd_req;    // read a cell (center or neighbor)
        logic [2:0]       rd_sel;    // which address to read
        logic             cap;       // capture read data into the center slot
        logic             rip_wr;    // write ripple sum
        logic             upd_wr;    // write updated cell
        logic             k_mul;     // start k product
        logic             k_div;     // finish k division
        logic             upd_calc;  // form v
        logic             upd_mul;   // form v*k
        logic             ld_out;    // drive the result beat
        logic             ptr_first; // set pointer to first cell of sweep
        logic             ptr_inc;   // advance pointer
    } t_cmd;

    typedef struct packed {
        logic ptr_last;   // pointer on last cell of current sweep
        logic in_grid;    // item coordinates inside grid
        logic no_inner;   // grid too small for an update
    } t_sts;

    // neighbor slots
    localparam logic [2:0] SL_C = 3'd0;
    localparam logic [2:0] SL_L = 3'd1;
    localparam logic [2:0] SL_R = 3'd2;
    localparam logic [2:0] SL_U = 3'd3;
    localparam logic [2:0] SL_D = 3'd4;

endpackage

// ===== design/wrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrg_ctrl
// Sequencer for ripple, read, clear and update sweep items.
// ----------------------------------------------------------------------------
module wrg_ctrl import wrg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state     r_state, n_state;
    logic [2:0] r_slot, n_slot;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_slot  <= SL_C;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        unique case (r_state)
            ST_INIT:    if (i_sts.ptr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_func)
                        FN_RIPPLE: n_state = i_sts.in_grid ? ST_RIP_RD : ST_DONE;
                        FN_READ:   n_state = i_sts.in_grid ? ST_RD_WAIT : ST_DONE;
                        FN_CLEAR:  n_state = ST_CLEAR;
                        FN_UPDATE: n_state = ST_K_MUL;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:   if (i_sts.ptr_last) n_state = ST_DONE;
            ST_RIP_RD:  n_state = ST_RIP_WR;
            ST_RIP_WR:  n_state = ST_DONE;
            ST_RD_WAIT: n_state = ST_DONE;
            ST_K_MUL:   n_state = ST_K_DIV;
            ST_K_DIV: begin
                n_state = i_sts.no_inner ? ST_DONE : ST_UPD_RD;
                n_slot  = SL_C;
            end
            ST_UPD_RD: begin
                if (r_slot == SL_D) n_state = ST_UPD_WAIT;
                n_slot = r_slot + 3'd1;
            end
            ST_UPD_WAIT: n_state = ST_UPD_CALC;
            ST_UPD_CALC: n_state = ST_UPD_MUL;
            ST_UPD_MUL:  n_state = ST_UPD_WR;
            ST_UPD_WR: begin
                n_state = i_sts.ptr_last ? ST_DONE : ST_UPD_RD;
                n_slot  = SL_C;
            end
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd    = '0;
        o_busy   = (r_state != ST_IDLE);
        o_done   = (r_state == ST_DONE);
        o_cmd.rd_sel = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ptr_first = i_start && (i_func == FN_CLEAR);
                o_cmd.rd_req    = 1'b1;
                o_cmd.rd_sel    = SL_C;
            end
            ST_INIT, ST_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            ST_RIP_RD: begin
                o_cmd.cap    = 1'b1;
                o_cmd.rd_sel = SL_C;
            end
            ST_RIP_WR:  o_cmd.rip_wr = 1'b1;
            ST_RD_WAIT: begin
                o_cmd.cap    = 1'b1;
                o_cmd.rd_sel = SL_C;
            end
            ST_K_MUL:   o_cmd.k_mul = 1'b1;
            ST_K_DIV: begin
                o_cmd.k_div     = 1'b1;
                o_cmd.ptr_first = 1'b1;
            end
            ST_UPD_RD:   o_cmd.rd_req = 1'b1;
            // last neighbor lands in its slot
            ST_UPD_WAIT: o_cmd.rd_req = 1'b0;
            ST_UPD_CALC: o_cmd.upd_calc = 1'b1;
            ST_UPD_MUL:  o_cmd.upd_mul = 1'b1;
            ST_UPD_WR: begin
                o_cmd.upd_wr  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
            end
            ST_DONE:    o_cmd.ld_out = 1'b1;
            default:    o_cmd = '0;
        endcase
    end

endmodule

// ===== design/wrg_dp.sv =====
// ----------------------------------------------------------------------------
// wrg_dp
// Height memory, sweep pointer, stencil and damping arithmetic.
// ----------------------------------------------------------------------------
module wrg_dp import wrg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    input  logic signed [15:0] i_amount,
    input  logic [9:0]         i_elapsed_ms,
    input  logic [8:0]         i_cols_cfg,
    input  logic [8:0]         i_rows_cfg,
    input  logic [15:0]        i_damping,
    output t_sts               o_sts,
    output logic signed [15:0] o_cell_height,
    output logic               o_status
);

    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rdata;
    logic [COL_W:0]     cols_use;
    logic [ROW_W:0]     rows_use;
    logic [COL_W-1:0]   r_col, n_pcol;
    logic [ROW_W-1:0]   r_row, n_prow;
    logic [1:0]         r_func;
    logic signed [15:0] r_amount;
    logic [9:0]         r_ms;
    logic               r_inside;
    logic [25:0]        r_kprod;
    logic [15:0]        r_k;
    logic [52:0]        kq_full;
    logic signed [15:0] r_nb [5];
    logic signed [17:0] r_v;
    logic signed [34:0] r_vk;
    logic [ADDR_W-1:0]  rd_addr, ptr_addr, wr_addr;
    logic signed [15:0] wr_data;
    logic               wr_en;
    logic signed [17:0] nsum;
    logic signed [17:0] half;
    logic signed [16:0] rsum;
    logic signed [35:0] damped;
    logic [9:0]         ms_sat;
    logic               in_now;

    // grid size in use
    assign cols_use = (i_cols_cfg > 9'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS)
                                                  : (COL_W+1)'(i_cols_cfg);
    assign rows_use = (i_rows_cfg > 9'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS)
                                                  : (ROW_W+1)'(i_rows_cfg);
    assign in_now   = ({1'b0, i_col} < 9'(cols_use)) && ({1'b0, i_row} < 9'(rows_use));

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_start && !i_busy) begin
            r_func   <= i_func;
            r_amount <= i_amount;
            r_ms     <= i_elapsed_ms;
            r_inside <= in_now;
        end
    end

    // pointer: coordinates of item or sweep position
    always_comb begin
        n_pcol = r_col;
        n_prow = r_row;
        if (i_start && !i_busy) begin
            n_pcol = COL_W'(i_col);
            n_prow = ROW_W'(i_row);
        end
        if (i_cmd.ptr_first) begin
            n_pcol = (r_func == FN_CLEAR && !i_busy) || (i_func == FN_CLEAR && !i_busy)
                     ? '0 : COL_W'(1);
            n_prow = (i_func == FN_CLEAR && !i_busy) ? '0 : ROW_W'(1);
        end else if (i_cmd.ptr_inc) begin
            if (i_cmd.clr_wr) begin
                n_pcol = r_col + 1'b1;
                if (r_col == COL_W'(MAX_COLS - 1)) n_prow = r_row + 1'b1;
            end else if ((COL_W+1)'(r_col) + 2 >= cols_use) begin
                n_pcol = COL_W'(1);
                n_prow = r_row + 1'b1;
            end else begin
                n_pcol = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_pcol;
            r_row <= n_prow;
        end
    end

    assign ptr_addr = {r_row, r_col};

    // status to the controller
    always_comb begin
        o_sts.in_grid  = in_now;
        o_sts.no_inner = (cols_use < 3) || (rows_use < 3);
        if (i_cmd.clr_wr)
            o_sts.ptr_last = (r_col == COL_W'(MAX_COLS - 1)) &&
                             (r_row == ROW_W'(MAX_ROWS - 1));
        else
            o_sts.ptr_last = ((COL_W+1)'(r_col) + 2 >= cols_use) &&
                             ((ROW_W+1)'(r_row) + 2 >= rows_use);
    end

    // read address per neighbor slot
    always_comb begin
        unique case (i_cmd.rd_sel)
            SL_L:    rd_addr = ptr_addr - ADDR_W'(1);
            SL_R:    rd_addr = ptr_addr + ADDR_W'(1);
            SL_U:    rd_addr = ptr_addr - ADDR_W'(MAX_COLS);
            SL_D:    rd_addr = ptr_addr + ADDR_W'(MAX_COLS);
            default: rd_addr = ptr_addr;
        endcase
        // idle: fetch the incoming item's cell so it is ready after acceptance
        if (!i_busy) rd_addr = {i_row, i_col};
    end

    // ripple sum, saturated at the write port
    assign rsum = 17'(r_nb[SL_C]) + 17'(r_amount);

    // write port
    always_comb begin
        wr_en   = i_cmd.clr_wr | i_cmd.rip_wr | i_cmd.upd_wr;
        wr_addr = ptr_addr;
        wr_data = '0;
        if (i_cmd.rip_wr) begin
            if (rsum > 17'sd32767)       wr_data = 16'sh7fff;
            else if (rsum < -17'sd32768) wr_data = -16'sh8000;
            else                         wr_data = rsum[15:0];
        end else if (i_cmd.upd_wr) begin
            if (damped > 36'sd32767)       wr_data = 16'sh7fff;
            else if (damped < -36'sd32768) wr_data = -16'sh8000;
            else                           wr_data = damped[15:0];
        end
    end

    // height memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    // neighbor capture: read data is registered in r_rdata, then written into its slot
    logic       r_rd_vld;
    logic [2:0] r_rd_slot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_req && i_busy;
        end
        r_rd_slot <= i_cmd.rd_sel;
        if (r_rd_vld) r_nb[r_rd_slot] <= r_rdata;
        else if (i_cmd.cap) r_nb[SL_C] <= r_rdata;
    end

    // damping coefficient, product then division by 1000 via reciprocal
    assign ms_sat  = (r_ms > 10'd1000) ? 10'd1000 : r_ms;
    assign kq_full = 53'(r_kprod) * 53'(K_RECIP);
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_mul) r_kprod <= 26'(i_damping) * 26'(10'd1000 - ms_sat);
        if (i_cmd.k_div) r_k <= kq_full[K_SHIFT+15:K_SHIFT];
    end

    // stencil: half of neighbor sum minus center, floor shift
    assign nsum = 18'(r_nb[SL_L]) + 18'(r_nb[SL_R]) + 18'(r_nb[SL_U]) + 18'(r_nb[SL_D]);
    assign half = nsum >>> 1;
    assign damped = 36'(r_v) - 36'(r_vk >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_calc) r_v <= half - 18'(r_nb[SL_C]);
        if (i_cmd.upd_mul)  r_vk <= 35'(r_v) * $signed({19'd0, r_k});
    end

    // result beat, driven while the strobe is high
    assign o_status      = i_cmd.ld_out && !r_inside &&
                           ((r_func == FN_RIPPLE) || (r_func == FN_READ));
    assign o_cell_height = (i_cmd.ld_out && r_func == FN_READ && r_inside) ? r_nb[SL_C] : '0;

endmodule

// ===== design/water_ripple_grid.sv =====
// ----------------------------------------------------------------------------
// water_ripple_grid
// Height field of signed Q8.8 cells with ripple, sweep, read and clear items.
// ----------------------------------------------------------------------------
// Usage: raise start with the item fields while busy is low; the item is
// taken on that edge. Exactly one result beat follows, shown for one cycle
// with o_done high; the receiver cannot stall it.
// Configuration goes over its own valid/ready port (index 0 columns,
// 1 rows, 2 damping) and is meant to be written while the block is idle.
// Steps: ripple reads the center cell and writes the saturated sum; read
// waits for the center cell; an out-of-grid ripple or read goes straight
// to the result; clear zeroes every cell; update forms k, then does five
// reads on the one read port and one write per interior cell. busy stays
// high through the result beat; the next item can be taken the cycle after.
// Reset: a clearing pass zeroes the memory; busy is high throughout and
// no item is taken, while configuration writes still go in.
// ----------------------------------------------------------------------------
module water_ripple_grid import wrg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_col,
    input  logic [7:0]         i_row,
    input  logic signed [15:0] i_amount,
    input  logic [9:0]         i_elapsed_ms,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [15:0] o_cell_height,
    output logic               o_status
);

    t_cmd        cmd;
    t_sts        sts;
    logic [8:0]  r_cols, r_rows;
    logic [15:0] r_damp;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 9'd256;
            r_rows <= 9'd256;
            r_damp <= 16'd655;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COLS: r_cols <= i_cfg_data[8:0];
                REG_ROWS: r_rows <= i_cfg_data[8:0];
                REG_DAMP: r_damp <= i_cfg_data;
                default:  r_damp <= r_damp;
            endcase
        end
    end

    wrg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    wrg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_start       (start),
        .i_busy        (busy),
        .i_func        (i_func),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_amount      (i_amount),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_cols_cfg    (r_cols),
        .i_rows_cfg    (r_rows),
        .i_damping     (r_damp),
        .o_sts         (sts),
        .o_cell_height (o_cell_height),
        .o_status      (o_status)
    );

    // one result beat per accepted item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("result beat while idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result beat repeated");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");

endmodule
